// ===== rtl/core/range_sum_min_max_mean_defines.svh =====
// ----------------------------------------------------------------------------
// range_sum_min_max_mean_defines
// Assertion macros for the range aggregate block.
// ----------------------------------------------------------------------------
`ifndef RANGE_SUM_MIN_MAX_MEAN_DEFINES_SVH
`define RANGE_SUM_MIN_MAX_MEAN_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define RSM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define RSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== rtl/core/rsmm_pkg.sv =====
// ----------------------------------------------------------------------------
// rsmm_pkg
// Shared widths, types and constants of the range aggregate block.
// ----------------------------------------------------------------------------
package rsmm_pkg;
	localparam int ScoreDepth = 4096;
	localparam int IdxW = 12;
	localparam int CntW = 13;
	localparam int ValW = 32;
	localparam int SumW = 44;
	localparam int QDepth = 2;
	localparam logic KindLoad = 1'b0;
	localparam logic KindQuery = 1'b1;

	typedef struct packed {
		logic kind;
		logic [IdxW-1:0] idx;
		logic [ValW-1:0] val;
		logic [IdxW-1:0] rs;
		logic [IdxW-1:0] re;
		logic ok;
	} cmd_t;
endpackage

// ===== rtl/core/rsmm_ram.sv =====
// ----------------------------------------------------------------------------
// rsmm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rsmm_ram #(
	parameter int Width = 32,
	parameter int Depth = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/core/rsmm_front.sv =====
// ----------------------------------------------------------------------------
// rsmm_front
// Accepts beats, checks load indices and query ranges, and buffers commands in a short queue.
// ----------------------------------------------------------------------------
module rsmm_front #(
	parameter int IdxBits = rsmm_pkg::IdxW,
	parameter int Depth = rsmm_pkg::ScoreDepth
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid,
	output logic                       stall,
	input  logic                       kind,
	input  logic [IdxBits-1:0]         score_index,
	input  logic signed [rsmm_pkg::ValW-1:0] score_value,
	input  logic [IdxBits-1:0]         range_start,
	input  logic [IdxBits-1:0]         range_end,
	input  logic [rsmm_pkg::CntW-1:0]  count_q,
	output rsmm_pkg::cmd_t             cmd,
	output logic                       cmd_valid,
	input  logic                       cmd_take
);
	localparam int QW = $clog2(rsmm_pkg::QDepth);
	rsmm_pkg::cmd_t q_q [rsmm_pkg::QDepth];
	logic [QW-1:0] wp_q, rp_q;
	logic [QW:0] n_q;
	logic push, pop;
	rsmm_pkg::cmd_t c;
	logic [rsmm_pkg::CntW:0] lim, ev;

	assign stall = (n_q == (QW+1)'(rsmm_pkg::QDepth));
	assign push = valid && !stall;
	assign pop = cmd_take && cmd_valid;
	assign cmd_valid = (n_q != '0);
	assign cmd = q_q[rp_q];

	always_comb begin
		lim = (int'(count_q) < Depth) ?
			(rsmm_pkg::CntW+1)'(count_q) : (rsmm_pkg::CntW+1)'(Depth);
		ev = (rsmm_pkg::CntW+1)'(range_end);
		c.kind = kind;
		c.idx = score_index;
		c.val = score_value;
		c.rs = range_start;
		c.re = range_end;
		c.ok = (range_end >= range_start) && (ev < lim);
		if (kind == rsmm_pkg::KindLoad) begin
			c.ok = (int'(score_index) < Depth);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q] <= c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			n_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			n_q <= n_q + (QW+1)'(push) - (QW+1)'(pop);
		end
	end
endmodule

// ===== rtl/core/rsmm_back.sv =====
// ----------------------------------------------------------------------------
// rsmm_back
// Executes loads and range walks over the score RAM, then divides.
// ----------------------------------------------------------------------------
module rsmm_back #(
	parameter int Depth = rsmm_pkg::ScoreDepth
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rsmm_pkg::cmd_t                    cmd,
	input  logic                              cmd_valid,
	output logic                              cmd_take,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              in_range,
	output logic signed [rsmm_pkg::SumW-1:0]  total,
	output logic signed [rsmm_pkg::ValW-1:0]  minimum,
	output logic signed [rsmm_pkg::ValW-1:0]  maximum,
	output logic [rsmm_pkg::CntW-1:0]         range_width,
	output logic signed [rsmm_pkg::ValW-1:0]  average
);
	localparam int AW = $clog2(Depth);
	localparam int SW = rsmm_pkg::SumW;
	localparam int CW = rsmm_pkg::CntW;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_READ = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_FIX  = 5'b01000,
		ST_OUT  = 5'b10000
	} st_t;

	st_t st_q;
	logic [AW-1:0] ra_q, end_q;
	logic rd_s1, last_s1, first_q;
	logic signed [SW-1:0] sum_q;
	logic signed [rsmm_pkg::ValW-1:0] lo_q, hi_q, rdata;
	logic [CW-1:0] w_q;
	logic [SW-1:0] num_q, rem_q;
	logic [5:0] dc_q;
	logic neg_q;
	logic [SW:0] trial;
	logic we;
	logic signed [SW-1:0] sx;
	logic [SW-1:0] quo;

	assign we = (st_q == ST_IDLE) && cmd_valid &&
		(cmd.kind == rsmm_pkg::KindLoad) && cmd.ok;
	assign cmd_take = (st_q == ST_IDLE);
	assign out_valid = (st_q == ST_OUT);

	rsmm_ram #(.Width(rsmm_pkg::ValW), .Depth(Depth)) u_ram (
		.clk(clk), .we(we), .waddr(AW'(cmd.idx)), .wdata(cmd.val),
		.raddr(ra_q), .rdata(rdata)
	);

	assign sx = SW'(rdata);
	assign trial = {rem_q, num_q[SW-1]} - (SW+1)'(w_q);
	assign quo = neg_q ? -num_q : num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			rd_s1 <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					rd_s1 <= 1'b0;
					if (cmd_valid && cmd.kind == rsmm_pkg::KindQuery) begin
						st_q <= cmd.ok ? ST_READ : ST_OUT;
					end
				end
				ST_READ: begin
					rd_s1 <= !last_s1 || !rd_s1;
					if (rd_s1 && last_s1) begin
						st_q <= ST_DIV;
					end
				end
				ST_DIV: if (dc_q == 6'(SW-1)) st_q <= ST_FIX;
				ST_FIX: st_q <= ST_OUT;
				ST_OUT: if (!out_stall) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				ra_q <= AW'(cmd.rs);
				end_q <= AW'(cmd.re);
				last_s1 <= (cmd.rs == cmd.re);
				first_q <= 1'b1;
				in_range <= cmd.ok;
				w_q <= cmd.ok ? CW'(cmd.re) - CW'(cmd.rs) + 1'b1 : '0;
				sum_q <= '0;
				lo_q <= '0;
				hi_q <= '0;
			end
			ST_READ: begin
				if (!rd_s1) begin
					last_s1 <= (ra_q == end_q);
					if (ra_q != end_q) ra_q <= ra_q + 1'b1;
				end else begin
					first_q <= 1'b0;
					sum_q <= first_q ? sx : sum_q + sx;
					lo_q <= (first_q || rdata < lo_q) ? rdata : lo_q;
					hi_q <= (first_q || rdata > hi_q) ? rdata : hi_q;
					last_s1 <= (ra_q == end_q);
					if (ra_q != end_q) ra_q <= ra_q + 1'b1;
				end
				if (rd_s1) begin
					neg_q <= first_q ? sx[SW-1] : (sum_q + sx) < 0;
					num_q <= first_q ? (sx < 0 ? -sx : sx) :
						((sum_q + sx) < 0 ? -(sum_q + sx) : sum_q + sx);
				end else begin
					neg_q <= sum_q[SW-1];
					num_q <= sum_q[SW-1] ? -sum_q : sum_q;
				end
				rem_q <= '0;
				dc_q <= '0;
			end
			ST_DIV: begin
				dc_q <= dc_q + 1'b1;
				if (!trial[SW]) begin
					rem_q <= trial[SW-1:0];
					num_q <= {num_q[SW-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[SW-2:0], num_q[SW-1]};
					num_q <= {num_q[SW-2:0], 1'b0};
				end
			end
			ST_FIX: average <= quo[rsmm_pkg::ValW-1:0];
			ST_OUT: ;
			default: ;
		endcase
		if (st_q == ST_IDLE) average <= '0;
	end

	assign total = sum_q;
	assign minimum = lo_q;
	assign maximum = hi_q;
	assign range_width = w_q;
endmodule

// ===== rtl/core/range_sum_min_max_mean.sv =====
// ----------------------------------------------------------------------------
// range_sum_min_max_mean
// Range aggregate query (sum, min, max, width, mean) over a score memory.
// ----------------------------------------------------------------------------
// A load beat writes one score while the back end is idle. A query walks
// its range at one RAM read per cycle, runs a 44-step restoring divider,
// then holds the result while out_stall is high. Out-of-range queries skip
// the walk and the divider. A two-entry command queue lets the input side
// run ahead while a result waits.
module range_sum_min_max_mean #(
	parameter int SCORE_DEPTH = rsmm_pkg::ScoreDepth
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rsmm_pkg::CntW-1:0]         cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              kind,
	input  logic [rsmm_pkg::IdxW-1:0]         score_index,
	input  logic signed [rsmm_pkg::ValW-1:0]  score_value,
	input  logic [rsmm_pkg::IdxW-1:0]         range_start,
	input  logic [rsmm_pkg::IdxW-1:0]         range_end,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              in_range,
	output logic signed [rsmm_pkg::SumW-1:0]  total,
	output logic signed [rsmm_pkg::ValW-1:0]  minimum,
	output logic signed [rsmm_pkg::ValW-1:0]  maximum,
	output logic [rsmm_pkg::CntW-1:0]         range_width,
	output logic signed [rsmm_pkg::ValW-1:0]  average
);
	logic [rsmm_pkg::CntW-1:0] count_q;
	rsmm_pkg::cmd_t cmd;
	logic cmd_valid, cmd_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= rsmm_pkg::CntW'(4096);
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	rsmm_front #(.Depth(SCORE_DEPTH)) u_front (
		.clk(clk), .arst_n(arst_n), .valid(in_valid), .stall(in_stall),
		.kind(kind), .score_index(score_index), .score_value(score_value),
		.range_start(range_start), .range_end(range_end), .count_q(count_q),
		.cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
	);

	rsmm_back #(.Depth(SCORE_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cmd_valid(cmd_valid),
		.cmd_take(cmd_take), .out_valid(out_valid), .out_stall(out_stall),
		.in_range(in_range), .total(total), .minimum(minimum),
		.maximum(maximum), .range_width(range_width), .average(average)
	);
endmodule

// ===== rtl/core/rsmm_checker.sv =====
// ----------------------------------------------------------------------------
// rsmm_checker
// Port-level checks of the range aggregate block.
// ----------------------------------------------------------------------------
`include "range_sum_min_max_mean_defines.svh"
module rsmm_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic in_range,
	input logic [43:0] total,
	input logic [12:0] range_width,
	input logic [31:0] average
);
	logic zero_ok;

	assign zero_ok = (total == '0) && (average == '0) && (range_width == '0);

	`RSM_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid, "beat dropped")
	`RSM_ASSERT_IMPL(a_zero, clk, arst_n, out_valid && !in_range, zero_ok, "bad zero")
	`RSM_ASSERT_IMPL(a_width, clk, arst_n, out_valid && in_range, range_width != '0, "zero width")
endmodule

bind range_sum_min_max_mean rsmm_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall),
	.in_range(in_range), .total(total), .range_width(range_width),
	.average(average)
);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Range aggregate testbench
// Loads scores and runs range queries against a behavioral scoreboard that
// tracks the score memory and the score count; checks sum, min, max, width
// and mean of every answered query, with bursty input and stalled output.
// ----------------------------------------------------------------------------
module testbench;
	localparam int IdxW = rsmm_pkg::IdxW;
	localparam int ValW = rsmm_pkg::ValW;
	localparam int SumW = rsmm_pkg::SumW;
	localparam int CntW = rsmm_pkg::CntW;
	localparam int ScoreDepth = rsmm_pkg::ScoreDepth;
	localparam logic KindLoad = rsmm_pkg::KindLoad;
	localparam logic KindQuery = rsmm_pkg::KindQuery;

	typedef struct {
		logic kind;
		logic [IdxW-1:0] idx;
		logic [ValW-1:0] val;
		logic [IdxW-1:0] rs;
		logic [IdxW-1:0] re;
	} beat_t;

	typedef struct {
		logic in_range;
		logic [SumW-1:0] total;
		logic [ValW-1:0] minimum;
		logic [ValW-1:0] maximum;
		logic [CntW-1:0] width;
		logic [ValW-1:0] average;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CntW-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic kind = 1'b0;
	logic [IdxW-1:0] score_index = '0;
	logic signed [ValW-1:0] score_value = '0;
	logic [IdxW-1:0] range_start = '0;
	logic [IdxW-1:0] range_end = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic in_range;
	logic signed [SumW-1:0] total;
	logic signed [ValW-1:0] minimum;
	logic signed [ValW-1:0] maximum;
	logic [CntW-1:0] range_width;
	logic signed [ValW-1:0] average;

	range_sum_min_max_mean i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .kind(kind),
		.score_index(score_index), .score_value(score_value),
		.range_start(range_start), .range_end(range_end),
		.out_valid(out_valid), .out_stall(out_stall), .in_range(in_range),
		.total(total), .minimum(minimum), .maximum(maximum),
		.range_width(range_width), .average(average)
	);

	beat_t pending_beats[$];
	answer_t expected_answers[$];
	logic [ValW-1:0] score_mem[ScoreDepth];
	bit written[ScoreDepth];
	int unsigned score_limit = ScoreDepth;
	int errors = 0;
	int loads_sent = 0, queries_sent = 0, answers_seen = 0, rejected_seen = 0;
	bit send_pause = 0;
	int gap_left = 0, burst_left = 0;
	int hold_off = 0;
	bit long_hold_req = 0;

	initial forever #5 clk = ~clk;

	function automatic answer_t summarize(input beat_t b);
		answer_t a;
		longint s, acc, lo, hi, mean;
		int unsigned w;
		a = '{default: '0};
		if (b.re < b.rs || b.re >= score_limit)
			return a;
		acc = 0;
		lo = 64'sh7fffffffffffffff;
		hi = -64'sh7fffffffffffffff;
		for (int j = b.rs; j <= b.re; j++) begin
			s = longint'(signed'(score_mem[j]));
			acc += s;
			if (s < lo) lo = s;
			if (s > hi) hi = s;
		end
		w = b.re - b.rs + 1;
		mean = acc / longint'(w);
		a.in_range = 1'b1;
		a.total = acc[SumW-1:0];
		a.minimum = lo[ValW-1:0];
		a.maximum = hi[ValW-1:0];
		a.width = w[CntW-1:0];
		a.average = mean[ValW-1:0];
		return a;
	endfunction

	// Tracks memory at queue time; order of beats through the block is kept.
	task automatic push_load(input int unsigned i, input logic [ValW-1:0] v);
		beat_t b;
		b = '{kind: KindLoad, idx: i[IdxW-1:0], val: v,
			rs: IdxW'($urandom), re: IdxW'($urandom)};
		score_mem[i] = v;
		written[i] = 1;
		pending_beats.push_back(b);
		loads_sent++;
	endtask

	task automatic push_query(input int unsigned s, input int unsigned e);
		beat_t b;
		b = '{kind: KindQuery, idx: IdxW'($urandom), val: ValW'($urandom),
			rs: s[IdxW-1:0], re: e[IdxW-1:0]};
		expected_answers.push_back(summarize(b));
		pending_beats.push_back(b);
		queries_sent++;
	endtask

	function automatic bit covered(input int unsigned s, input int unsigned e);
		if (e < s || e >= score_limit) return 1;
		for (int j = s; j <= e; j++)
			if (!written[j]) return 0;
		return 1;
	endfunction

	function automatic logic [ValW-1:0] rand_score();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return ValW'($urandom_range(0, 65535));
			3: return -ValW'($urandom_range(0, 65535));
			default: return ValW'($urandom);
		endcase
	endfunction

	task automatic drain();
		while (pending_beats.size() != 0 || expected_answers.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_count(input int unsigned n);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= n[CntW-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		score_limit = n;
	endtask

	task automatic random_query();
		int unsigned s, e, r;
		r = $urandom_range(0, 9);
		s = $urandom_range(0, 63);
		if (r == 0) begin
			e = $urandom_range(0, 511);
			s = $urandom_range(0, 511);
		end else if (r == 1) begin
			e = s == 0 ? 0 : $urandom_range(0, s - 1);
		end else begin
			e = s + $urandom_range(0, 40);
		end
		if (!covered(s, e)) begin
			s = $urandom_range(0, 63);
			e = s;
		end
		if (covered(s, e)) push_query(s, e);
	endtask

	// Driver: bursts and gaps, payload held while stalled.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				void'(pending_beats.pop_front());
				if (burst_left > 0) burst_left--;
			end
			if (gap_left > 0) gap_left--;
			else if (burst_left == 0) begin
				burst_left = $urandom_range(1, 30);
				gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
			end
			if (in_valid && in_stall) begin
			end else if (pending_beats.size() != 0 && gap_left == 0 && !send_pause) begin
				in_valid <= 1'b1;
				kind <= pending_beats[0].kind;
				score_index <= pending_beats[0].idx;
				score_value <= pending_beats[0].val;
				range_start <= pending_beats[0].rs;
				range_end <= pending_beats[0].re;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall pattern with one long hold-off.
	always @(posedge clk) begin
		if (arst_n) begin
			if (long_hold_req && hold_off == 0) begin
				hold_off = 400;
				long_hold_req = 0;
			end
			if (hold_off > 0) begin
				hold_off--;
				out_stall <= 1'b1;
			end else begin
				case (($urandom_range(0, 3)))
					0: out_stall <= 1'b1;
					default: out_stall <= 1'b0;
				endcase
			end
		end
	end

	// Monitor.
	always @(posedge clk) begin
		answer_t x;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_answers.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				x = expected_answers.pop_front();
				answers_seen++;
				if (!x.in_range) rejected_seen++;
				if (in_range !== x.in_range) begin
					$error("in_range exp %0d got %0d", x.in_range, in_range); errors++;
				end
				if (total !== x.total) begin
					$error("total exp %0h got %0h", x.total, total); errors++;
				end
				if (minimum !== x.minimum) begin
					$error("minimum exp %0h got %0h", x.minimum, minimum); errors++;
				end
				if (maximum !== x.maximum) begin
					$error("maximum exp %0h got %0h", x.maximum, maximum); errors++;
				end
				if (range_width !== x.width) begin
					$error("range_width exp %0d got %0d", x.width, range_width); errors++;
				end
				if (average !== x.average) begin
					$error("average exp %0h got %0h", x.average, average); errors++;
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		int unsigned s;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		push_load(0, 32'h7fffffff);
		push_load(1, 32'h80000000);
		push_load(2, 32'h00000000);
		push_load(3, 32'hffffffff);
		push_load(4, 32'h00018000);
		push_load(4095, 32'hfffe8000);
		push_load(4094, 32'h7fffffff);
		push_query(0, 0);
		push_query(0, 4);
		push_query(1, 3);
		push_query(3, 4);
		push_query(4, 2);
		push_query(4094, 4095);
		push_query(4095, 4095);
		set_count(4095);
		push_query(4094, 4094);
		push_query(4094, 4095);
		set_count(1);
		push_query(0, 0);
		push_query(0, 1);
		set_count(0);
		push_query(0, 0);
		set_count(4096);

		for (int i = 0; i < 512; i++)
			if (!written[i]) push_load(i, rand_score());
		push_query(0, 511);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			for (int n = 0; n < 400; n++) begin
				if ($urandom_range(0, 2) == 0)
					push_load($urandom_range(0, 511), rand_score());
				else
					random_query();
				if (n == 200 && phase == 1) begin
					long_hold_req = 1;
					for (int k = 0; k < 40; k++) random_query();
				end
				if (n == 300 && phase == 2) begin
					while (pending_beats.size() != 0) @(posedge clk);
					send_pause = 1;
					while (expected_answers.size() != 0) @(posedge clk);
					send_pause = 0;
				end
			end
			s = phase == 0 ? 40 : phase == 1 ? 4096 : phase == 2 ? 2 : 4096;
			set_count(s);
		end
		drain();
		$display("%0d loads, %0d queries, %0d answers (%0d out of range) checked",
			loads_sent, queries_sent, answers_seen, rejected_seen);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/rsmm_pkg.sv
rtl/core/rsmm_ram.sv
rtl/core/rsmm_front.sv
rtl/core/rsmm_back.sv
rtl/core/range_sum_min_max_mean.sv
rtl/core/rsmm_checker.sv
bench/testbench.sv
